// ----- sv/albc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albc_pkg
// Types, register indexes and constants shared by the ambient light
// brightness controller.
// ----------------------------------------------------------------------------
package albc_pkg;

    localparam int LUX_WIDTH   = 24;
    localparam int MAX_POINTS  = 8;
    localparam int PT_LUX_W    = 24;
    localparam int LVL_W       = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PT_IDX_W    = 3;
    localparam int ALPHA_W     = 9;

    localparam logic [LVL_W-1:0]   LEVEL_NO_MATCH = 8'd128;
    localparam logic [LVL_W-1:0]   TARGET_RESET   = 8'd128;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 9'd77;
    localparam logic [31:0]        LIMITS_RESET   = 32'h0505_FF0A;
    localparam logic [3:0]         POINTS_RESET   = 4'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_POINTS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE = 3'd7;

    typedef struct packed {
        logic [LUX_WIDTH-1:0] lux_sample;
        logic                 read_failed;
    } t_in_item;

    typedef struct packed {
        logic [LVL_W-1:0]     applied_level;
        logic                 level_changed;
        logic [LVL_W-1:0]     target_level;
        logic [LUX_WIDTH-1:0] smoothed_light;
    } t_out_item;

    // One table point as packed in a 32-bit half of a map pair.
    typedef struct packed {
        logic [LVL_W-1:0]    level;
        logic [PT_LUX_W-1:0] lux;
    } t_point;

    // The minimum sits in the low byte, the fade step in the high byte.
    typedef struct packed {
        logic [LVL_W-1:0] step;
        logic [LVL_W-1:0] hyst;
        logic [LVL_W-1:0] hi;
        logic [LVL_W-1:0] lo;
    } t_limits;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_AVG    = 8'b0000_0010,
        ST_FIRST  = 8'b0000_0100,
        ST_LAST   = 8'b0000_1000,
        ST_SEARCH = 8'b0001_0000,
        ST_MUL    = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_LIMIT  = 8'b1000_0000
    } t_state;

endpackage

// ----- sv/ambient_light_brightness_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_brightness_controller
// Smooths light samples, maps them through a piecewise-linear table and
// slews the backlight level toward a hysteresis-filtered target.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------
//  in       | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A disabled block or a failed read goes straight from idle to the limit
// step; otherwise one shared multiplier serves the average and the
// interpolation product, the segment search reads one table point per cycle
// and the quotient comes from an 8-step restoring divider. Reset is
// synchronous and needs no clearing pass. A new item is taken while the
// previous result still waits in the output register; the sequencer holds
// its last step until that register is free.
// ----------------------------------------------------------------------------
module ambient_light_brightness_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  albc_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output albc_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [albc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [albc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import albc_pkg::*;

    // Configuration.
    logic [CFG_DATA_W-1:0] r_map_pair [4];
    logic [3:0]            r_map_points;
    logic [ALPHA_W-1:0]    r_alpha;
    t_limits               r_limits;
    logic                  r_enable;

    // Block state.
    logic [LUX_WIDTH-1:0]  r_avg, n_avg;
    logic [LVL_W-1:0]      r_target, n_target;
    logic [LVL_W-1:0]      r_applied, n_applied;

    // Sequencer and work registers.
    t_state                r_state, n_state;
    logic [LUX_WIDTH-1:0]  r_sample, n_sample;
    logic                  r_skip, n_skip;
    logic [PT_IDX_W-1:0]   r_idx, n_idx;
    t_point                r_prev, n_prev;
    logic [LVL_W-1:0]      r_b0, n_b0;
    logic [LVL_W-1:0]      r_dmag, n_dmag;
    logic                  r_neg, n_neg;
    logic [PT_LUX_W-1:0]   r_span, n_span;
    logic [PT_LUX_W-1:0]   r_off, n_off;
    logic [31:0]           r_rem, n_rem;
    logic [LVL_W-1:0]      r_quot, n_quot;
    logic [2:0]            r_cnt, n_cnt;
    logic [LVL_W-1:0]      r_lvl, n_lvl;

    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    // Combinational helpers.
    logic                  in_accept;
    logic                  out_free;
    logic [CFG_DATA_W-1:0] pt_pair;
    t_point                pt;
    logic [PT_IDX_W-1:0]   last_idx;
    logic [ALPHA_W-1:0]    alpha_sat;
    logic signed [24:0]    mul_a;
    logic signed [9:0]     mul_b;
    logic signed [34:0]    mul_p;
    logic signed [35:0]    avg_acc;
    logic [8:0]            delta;
    logic [31:0]           div_cmp;
    logic [LVL_W-1:0]      quot_next;
    logic [LVL_W-1:0]      q_signed;
    logic [LVL_W-1:0]      lvl_lo, lvl_c, dt, da, fade_t, fade_a;
    logic                  fade_chg;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Single table point read port.
    assign pt_pair  = r_map_pair[r_idx[2:1]];
    assign pt       = r_idx[0] ? t_point'(pt_pair[63:32]) : t_point'(pt_pair[31:0]);

    always_comb begin
        if (r_map_points == 4'd0) begin
            last_idx = '0;
        end else if (r_map_points > 4'(MAX_POINTS)) begin
            last_idx = PT_IDX_W'(MAX_POINTS - 1);
        end else begin
            last_idx = PT_IDX_W'(r_map_points - 4'd1);
        end
    end

    assign alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    // Shared multiplier: average update and interpolation product.
    always_comb begin
        if (r_state == ST_AVG) begin
            mul_a = $signed({1'b0, r_sample}) - $signed({1'b0, r_avg});
            mul_b = $signed({1'b0, alpha_sat});
        end else begin
            mul_a = $signed({1'b0, r_off});
            mul_b = $signed({2'b00, r_dmag});
        end
    end
    assign mul_p   = mul_a * mul_b;
    assign avg_acc = $signed({4'b0000, r_avg, 8'h00}) + 36'(mul_p);

    assign delta = {1'b0, pt.level} - {1'b0, r_prev.level};

    // Restoring division step; the quotient never exceeds eight bits.
    assign div_cmp   = {8'h00, r_span} << r_cnt;
    always_comb begin
        quot_next = r_quot;
        if (r_rem >= div_cmp) begin
            quot_next[r_cnt] = 1'b1;
        end
    end
    assign q_signed = r_neg ? (8'd0 - quot_next) : quot_next;

    // Limits, hysteresis and fade.
    always_comb begin
        lvl_lo  = (r_lvl < r_limits.lo) ? r_limits.lo : r_lvl;
        lvl_c   = (lvl_lo > r_limits.hi) ? r_limits.hi : lvl_lo;
        dt      = (lvl_c > r_target) ? (lvl_c - r_target) : (r_target - lvl_c);
        fade_t  = (dt >= r_limits.hyst) ? lvl_c : r_target;
        da      = (fade_t > r_applied) ? (fade_t - r_applied) : (r_applied - fade_t);
        fade_chg = (fade_t != r_applied);
        if (!fade_chg || da <= r_limits.step) begin
            fade_a = fade_t;
        end else if (fade_t > r_applied) begin
            fade_a = r_applied + r_limits.step;
        end else begin
            fade_a = r_applied - r_limits.step;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_avg       = r_avg;
        n_target    = r_target;
        n_applied   = r_applied;
        n_sample    = r_sample;
        n_skip      = r_skip;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_b0        = r_b0;
        n_dmag      = r_dmag;
        n_neg       = r_neg;
        n_span      = r_span;
        n_off       = r_off;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_lvl       = r_lvl;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_sample = i_in_data.lux_sample;
                    n_skip   = !r_enable || i_in_data.read_failed;
                    n_state  = (!r_enable || i_in_data.read_failed) ? ST_LIMIT : ST_AVG;
                end
            end
            ST_AVG: begin
                if (r_avg == '0) begin
                    n_avg = r_sample;
                end else begin
                    n_avg = avg_acc[8 +: LUX_WIDTH];
                end
                n_idx   = '0;
                n_state = ST_FIRST;
            end
            ST_FIRST: begin
                if (r_avg <= pt.lux) begin
                    n_lvl   = pt.level;
                    n_state = ST_LIMIT;
                end else begin
                    n_prev  = pt;
                    n_idx   = last_idx;
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                if (r_avg >= pt.lux) begin
                    n_lvl   = pt.level;
                    n_state = ST_LIMIT;
                end else begin
                    n_idx   = PT_IDX_W'(1);
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_avg >= r_prev.lux && r_avg <= pt.lux) begin
                    n_b0   = r_prev.level;
                    n_neg  = delta[8];
                    n_dmag = delta[8] ? (8'd0 - delta[7:0]) : delta[7:0];
                    n_span = pt.lux - r_prev.lux;
                    n_off  = r_avg - r_prev.lux;
                    if (pt.lux == r_prev.lux) begin
                        // A segment of zero width adds nothing.
                        n_lvl   = r_prev.level;
                        n_state = ST_LIMIT;
                    end else begin
                        n_state = ST_MUL;
                    end
                end else if (r_idx == last_idx) begin
                    n_lvl   = LEVEL_NO_MATCH;
                    n_state = ST_LIMIT;
                end else begin
                    n_prev = pt;
                    n_idx  = r_idx + PT_IDX_W'(1);
                end
            end
            ST_MUL: begin
                n_rem   = mul_p[31:0];
                n_quot  = '0;
                n_cnt   = 3'd7;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_quot = quot_next;
                if (r_rem >= div_cmp) begin
                    n_rem = r_rem - div_cmp;
                end
                if (r_cnt == 3'd0) begin
                    n_lvl   = r_b0 + q_signed;
                    n_state = ST_LIMIT;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            ST_LIMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_skip) begin
                        n_out.applied_level = r_applied;
                        n_out.level_changed = 1'b0;
                        n_out.target_level  = r_target;
                    end else begin
                        n_target  = fade_t;
                        n_applied = fade_a;
                        n_out.applied_level = fade_a;
                        n_out.level_changed = fade_chg;
                        n_out.target_level  = fade_t;
                    end
                    n_out.smoothed_light = r_avg;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_pair[0] <= '0;
            r_map_pair[1] <= '0;
            r_map_pair[2] <= '0;
            r_map_pair[3] <= '0;
            r_map_points  <= POINTS_RESET;
            r_alpha       <= ALPHA_RESET;
            r_limits      <= t_limits'(LIMITS_RESET);
            r_enable      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_PAIR_0:  r_map_pair[0] <= i_cfg_data;
                REG_MAP_PAIR_1:  r_map_pair[1] <= i_cfg_data;
                REG_MAP_PAIR_2:  r_map_pair[2] <= i_cfg_data;
                REG_MAP_PAIR_3:  r_map_pair[3] <= i_cfg_data;
                REG_MAP_POINTS:  r_map_points  <= i_cfg_data[3:0];
                REG_ALPHA:       r_alpha       <= i_cfg_data[ALPHA_W-1:0];
                REG_LIMITS:      r_limits      <= t_limits'(i_cfg_data[31:0]);
                REG_AUTO_ENABLE: r_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Control and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_avg       <= '0;
            r_target    <= TARGET_RESET;
            r_applied   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_avg       <= n_avg;
            r_target    <= n_target;
            r_applied   <= n_applied;
        end
    end

    // Work registers.
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_skip   <= n_skip;
        r_idx    <= n_idx;
        r_prev   <= n_prev;
        r_b0     <= n_b0;
        r_dmag   <= n_dmag;
        r_neg    <= n_neg;
        r_span   <= n_span;
        r_off    <= n_off;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_cnt    <= n_cnt;
        r_lvl    <= n_lvl;
        r_out    <= n_out;
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ambient light brightness controller. Light
// samples go in through a queue-fed driver, every result is checked field by
// field against an in-bench model of the smoothing, the table lookup, the
// limits, the hysteresis and the fade. Directed items cover table ends,
// segment interiors and the configuration corners, then random tables,
// limits and samples run under random gaps, stalls and a long output hold.
// ----------------------------------------------------------------------------
module tb;
    import albc_pkg::*;

    localparam int PRESSURE_HOLD  = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 25;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              in_data = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the configuration registers.
    logic [63:0] map_pair_cfg [4] = '{default: '0};
    logic [3:0]  points_cfg = POINTS_RESET;
    logic [8:0]  alpha_cfg = ALPHA_RESET;
    logic [31:0] limits_cfg = LIMITS_RESET;
    logic        enable_cfg = 1'b1;

    // Mirror of the controller state.
    logic [23:0] avg_lux = '0;
    logic [7:0]  target_lvl = TARGET_RESET;
    logic [7:0]  applied_lvl = '0;

    logic [63:0] setup_pairs [4];
    t_in_item    light_samples [$];
    t_out_item   brightness_due [$];

    int gap_max = 0;
    int stall_max = 0;
    int hold_trigger = 0;
    int error_count = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    ambient_light_brightness_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_point map_point(input int unsigned k);
        logic [63:0] pair;
        pair = map_pair_cfg[k >> 1];
        return t_point'(k[0] ? pair[63:32] : pair[31:0]);
    endfunction

    function automatic logic [7:0] table_level(input logic [23:0] lux);
        int unsigned n;
        t_point      p_head;
        t_point      p_tail;
        t_point      p0;
        t_point      p1;
        longint      dl;
        longint      db;
        longint      width;
        longint      q;
        n = (points_cfg == 0) ? 1 : ((points_cfg > MAX_POINTS) ? MAX_POINTS : points_cfg);
        p_head = map_point(0);
        p_tail = map_point(n - 1);
        if (lux <= p_head.lux) return p_head.level;
        if (lux >= p_tail.lux) return p_tail.level;
        for (int unsigned i = 0; i + 1 < n; i++) begin
            p0 = map_point(i);
            p1 = map_point(i + 1);
            if (lux >= p0.lux && lux <= p1.lux) begin
                dl = longint'(lux) - longint'(p0.lux);
                db = longint'(p1.level) - longint'(p0.level);
                width = longint'(p1.lux) - longint'(p0.lux);
                q = 0;
                // Signed division truncates toward zero, as the block does.
                if (width > 0) q = (dl * db) / width;
                return 8'(longint'(p0.level) + q);
            end
        end
        return LEVEL_NO_MATCH;
    endfunction

    // Advances the mirrored state by one accepted item and queues its result.
    task automatic step_controller(input t_in_item item);
        t_out_item       res;
        longint unsigned a;
        longint unsigned acc;
        logic [7:0]      lo;
        logic [7:0]      hi;
        logic [7:0]      hyst;
        logic [7:0]      fade;
        logic [7:0]      lvl;
        logic [7:0]      diff;
        lo = limits_cfg[7:0];
        hi = limits_cfg[15:8];
        hyst = limits_cfg[23:16];
        fade = limits_cfg[31:24];
        res.level_changed = 1'b0;
        if (enable_cfg && !item.read_failed) begin
            if (avg_lux == 0) begin
                avg_lux = item.lux_sample;
            end else begin
                a = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
                acc = a * item.lux_sample + (256 - a) * avg_lux;
                avg_lux = 24'(acc >> 8);
            end
            lvl = table_level(avg_lux);
            if (lvl < lo) lvl = lo;
            if (lvl > hi) lvl = hi;
            diff = (lvl > target_lvl) ? lvl - target_lvl : target_lvl - lvl;
            if (diff >= hyst) target_lvl = lvl;
            if (applied_lvl != target_lvl) begin
                diff = (target_lvl > applied_lvl) ? target_lvl - applied_lvl
                                                  : applied_lvl - target_lvl;
                if (diff <= fade) applied_lvl = target_lvl;
                else if (target_lvl > applied_lvl) applied_lvl = applied_lvl + fade;
                else applied_lvl = applied_lvl - fade;
                res.level_changed = 1'b1;
            end
        end
        res.applied_level = applied_lvl;
        res.target_level = target_lvl;
        res.smoothed_light = avg_lux;
        brightness_due.push_back(res);
    endtask

    task automatic report_mismatch(input string what);
        $display("result %0d: %s", results_seen, what);
        error_count++;
    endtask

    // Input driver.
    always @(posedge i_clk) begin
        int gap_left;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                step_controller(in_data);
                if (gap_max > 0 && $urandom_range(0, 1)) gap_left = $urandom_range(1, gap_max);
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (light_samples.size() > 0) begin
                    in_data <= light_samples.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stall.
    always @(posedge i_clk) begin
        int        stall_left;
        int        hold_left;
        int        hold_seen;
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                hold_left = PRESSURE_HOLD;
            end
            if (o_out_valid && !out_stall) begin
                if (brightness_due.size() == 0) begin
                    report_mismatch("item with no result expected");
                end else begin
                    want = brightness_due.pop_front();
                    if (o_out_data.applied_level !== want.applied_level)
                        report_mismatch($sformatf("applied_level %0d, expected %0d",
                            o_out_data.applied_level, want.applied_level));
                    if (o_out_data.level_changed !== want.level_changed)
                        report_mismatch($sformatf("level_changed %0b, expected %0b",
                            o_out_data.level_changed, want.level_changed));
                    if (o_out_data.target_level !== want.target_level)
                        report_mismatch($sformatf("target_level %0d, expected %0d",
                            o_out_data.target_level, want.target_level));
                    if (o_out_data.smoothed_light !== want.smoothed_light)
                        report_mismatch($sformatf("smoothed_light %0d, expected %0d",
                            o_out_data.smoothed_light, want.smoothed_light));
                end
                results_seen++;
                if (stall_max > 0 && $urandom_range(0, 1)) stall_left = $urandom_range(1, stall_max);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_sample(input logic [23:0] lux, input logic failed);
        light_samples.push_back(t_in_item'{lux_sample: lux, read_failed: failed});
    endtask

    // Checked between edges, so the driver's updates of the last edge are settled.
    task automatic wait_idle();
        while (light_samples.size() != 0 || in_valid || brightness_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_MAP_PAIR_0:  map_pair_cfg[0] = data;
            REG_MAP_PAIR_1:  map_pair_cfg[1] = data;
            REG_MAP_PAIR_2:  map_pair_cfg[2] = data;
            REG_MAP_PAIR_3:  map_pair_cfg[3] = data;
            REG_MAP_POINTS:  points_cfg = data[3:0];
            REG_ALPHA:       alpha_cfg = data[8:0];
            REG_LIMITS:      limits_cfg = data[31:0];
            REG_AUTO_ENABLE: enable_cfg = data[0];
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [3:0] points, input logic [8:0] alpha,
                              input logic [31:0] limits, input logic enable);
        write_reg(REG_MAP_PAIR_0, setup_pairs[0]);
        write_reg(REG_MAP_PAIR_1, setup_pairs[1]);
        write_reg(REG_MAP_PAIR_2, setup_pairs[2]);
        write_reg(REG_MAP_PAIR_3, setup_pairs[3]);
        write_reg(REG_MAP_POINTS, 64'(points));
        write_reg(REG_ALPHA, 64'(alpha));
        write_reg(REG_LIMITS, 64'(limits));
        write_reg(REG_AUTO_ENABLE, 64'(enable));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic build_table(input int unsigned range_top, input bit ordered);
        t_point      pts [8];
        int unsigned lux_acc;
        lux_acc = $urandom_range(0, range_top / 16);
        for (int k = 0; k < 8; k++) begin
            if (ordered) begin
                pts[k].lux = 24'(lux_acc);
                // Now and then two points share a lux value.
                if ($urandom_range(0, 7) != 0) lux_acc += $urandom_range(1, range_top / 8);
                if (lux_acc > 24'hFFFFFF) lux_acc = 24'hFFFFFF;
            end else begin
                pts[k].lux = 24'($urandom_range(0, range_top));
            end
            pts[k].level = 8'($urandom_range(0, 255));
        end
        for (int k = 0; k < 4; k++) setup_pairs[k] = {pts[2 * k + 1], pts[2 * k]};
    endtask

    function automatic logic [23:0] pick_lux(input int unsigned range_top);
        int unsigned sel;
        int unsigned base;
        int unsigned off;
        t_point      near_pt;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            // Close to a table point, where segments begin and end.
            near_pt = map_point($urandom_range(0, 7));
            base = near_pt.lux;
            off = $urandom_range(0, range_top / 64 + 2);
            if ($urandom_range(0, 1)) begin
                base = base + off;
                return (base > 24'hFFFFFF) ? 24'hFFFFFF : 24'(base);
            end
            return (base > off) ? 24'(base - off) : 24'd0;
        end
        if (sel < 8) return 24'($urandom_range(0, range_top));
        if (sel < 9) return 24'($urandom);
        return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
    endfunction

    function automatic logic [31:0] pick_limits();
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] hyst;
        logic [7:0] fade;
        lo = 8'($urandom_range(0, 60));
        hi = 8'($urandom_range(180, 255));
        hyst = 8'($urandom_range(0, 12));
        fade = 8'($urandom_range(0, 24));
        case ($urandom_range(0, 5))
            0: {fade, hyst, hi, lo} = $urandom;
            1: hyst = 8'd0;
            2: fade = 8'd0;
            3: fade = 8'hFF;
            default: ;
        endcase
        return {fade, hyst, hi, lo};
    endfunction

    function automatic logic [8:0] pick_alpha();
        case ($urandom_range(0, 7))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd255;
            3: return ALPHA_ONE;
            4: return 9'h1FF;
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    function automatic logic [3:0] pick_points();
        case ($urandom_range(0, 9))
            0: return 4'd0;
            1: return 4'd1;
            2: return 4'd15;
            3: return 4'd9;
            default: return 4'($urandom_range(2, 8));
        endcase
    endfunction

    initial begin
        int unsigned range_top;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: an all-zero table clamped up to the minimum.
        queue_sample(24'd0, 1'b0);
        queue_sample(24'd5000, 1'b0);
        wait_idle();

        // Ordered table with a falling segment; alpha of one makes the
        // average follow each sample, so every table region is hit directly.
        setup_pairs[0] = {8'd200, 24'd5000, 8'd20, 24'd1000};
        setup_pairs[1] = {8'd250, 24'd100000, 8'd60, 24'd20000};
        setup_pairs[2] = {8'd0, 24'd0, 8'd255, 24'hFFFFFF};
        setup_pairs[3] = '0;
        load_setup(4'd5, ALPHA_ONE, {8'd255, 8'd0, 8'd255, 8'd0}, 1'b1);
        queue_sample(24'd0, 1'b0);
        queue_sample(24'd1000, 1'b0);
        queue_sample(24'd3000, 1'b0);
        queue_sample(24'd5000, 1'b0);
        queue_sample(24'd12345, 1'b0);
        queue_sample(24'd20000, 1'b0);
        queue_sample(24'd60000, 1'b0);
        queue_sample(24'hFFFFFF, 1'b0);
        queue_sample(24'd777, 1'b1);
        queue_sample(24'hFFFFFE, 1'b0);
        queue_sample(24'd1, 1'b0);
        wait_idle();

        // Minimum above maximum, zero fade, saturating alpha, zero points.
        load_setup(4'd0, 9'h1FF, {8'd0, 8'd30, 8'd50, 8'd200}, 1'b1);
        queue_sample(24'd40000, 1'b0);
        queue_sample(24'd3000, 1'b0);
        queue_sample(24'd100, 1'b1);
        queue_sample(24'd100, 1'b0);
        wait_idle();

        // Disabled block, too many points, zero alpha.
        load_setup(4'd15, 9'd0, {8'd1, 8'd255, 8'd255, 8'd0}, 1'b0);
        queue_sample(24'd9000, 1'b0);
        queue_sample(24'hABCDEF, 1'b1);
        queue_sample(24'd0, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 2))
                0: range_top = 2000;
                1: range_top = 200000;
                default: range_top = 24'hFFFFFF;
            endcase
            build_table(range_top, $urandom_range(0, 6) != 0);
            load_setup(pick_points(), pick_alpha(), pick_limits(), $urandom_range(0, 9) != 0);
            case (phase)
                0: begin gap_max = 0;  stall_max = 0;  end
                2: begin gap_max = 0;  stall_max = 16; end
                3: begin gap_max = 16; stall_max = 0;  end
                4: begin gap_max = 0;  stall_max = 16; end
                default: begin gap_max = 16; stall_max = 16; end
            endcase
            for (int n = 0; n < 200; n++)
                queue_sample(pick_lux(range_top), $urandom_range(0, 9) == 0);
            // The receiver holds off while the sender keeps offering items.
            if (phase == 2) hold_trigger++;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
